[hw/rtl/msort_pkg.sv]
`default_nettype none

package msort_pkg;

    localparam int KEY_W           = 32;
    localparam int IDX_W           = 6;
    localparam int MAX_ENTRIES_DEF = 64;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    selected;
        logic                    last_entry;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        position;
        logic [IDX_W-1:0]        source_index;
        logic signed [KEY_W-1:0] sorted_key;
        logic                    last_result;
    } t_out_item;

    // one slot of the sorted chain
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_chain_ctl;

endpackage

`default_nettype wire

[hw/rtl/msort_cell.sv]
`default_nettype none

module msort_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire msort_pkg::t_chain_ctl i_ctl,
    input  wire msort_pkg::t_entry     i_new,
    input  wire msort_pkg::t_entry     i_prev,
    input  wire logic                  i_prev_gt,
    input  wire msort_pkg::t_entry     i_next,
    output      msort_pkg::t_entry     o_entry,
    output      logic                  o_gt
);

    msort_pkg::t_entry r_entry;
    msort_pkg::t_entry n_entry;

    // empty slots count as greater, so new entries land behind equal keys
    assign o_gt = !r_entry.valid || ($signed(r_entry.key) > $signed(i_new.key));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (o_gt) begin
                n_entry = i_prev_gt ? i_prev : i_new;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.key <= n_entry.key;
        r_entry.idx <= n_entry.idx;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

[hw/rtl/msort_chain.sv]
`default_nettype none

module msort_chain #(
    parameter int MAX_ENTRIES = msort_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire msort_pkg::t_chain_ctl i_ctl,
    input  wire msort_pkg::t_entry     i_new,
    output      msort_pkg::t_entry     o_head
);

    msort_pkg::t_entry w_entry [MAX_ENTRIES];
    logic              w_gt    [MAX_ENTRIES];
    msort_pkg::t_entry w_empty;

    assign w_empty = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        msort_pkg::t_entry w_prev;
        msort_pkg::t_entry w_next;
        logic              w_prev_gt;

        if (g == 0) begin : g_first
            assign w_prev    = w_empty;
            assign w_prev_gt = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_entry[g-1];
            assign w_prev_gt = w_gt[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_next = w_empty;
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        msort_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (i_ctl),
            .i_new     (i_new),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

`default_nettype wire

[hw/rtl/masked_numeric_sort.sv]
// Channel   Direction  Ports                               Moves
// in        sink       i_in_valid/o_in_ready/i_in_data     one list entry per request
// out       source     o_out_valid/i_out_ready/o_out_data  one list position per request
//
// While loading, the input is always ready: each selected entry drops straight into
// its sorted slot in the cell chain, and entries are stored in the position memory
// while room remains. After the last entry, unless the output stalls, the list
// drains one position per cycle via the registered memory read and output register.
// No entry is taken from the closing entry until the final position is delivered.
// Synchronous active-low reset empties the chain and starts a new list.
`default_nettype none

module masked_numeric_sort #(
    parameter int MAX_ENTRIES = msort_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire msort_pkg::t_in_item  i_in_data,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    output      msort_pkg::t_out_item o_out_data
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W = msort_pkg::KEY_W;
    localparam int IDX_W = msort_pkg::IDX_W;

    msort_pkg::t_state     r_state;
    msort_pkg::t_state     n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_fetch_pos;
    logic                  r_a_valid;
    logic [AW-1:0]         r_a_pos;
    logic signed [KEY_W-1:0] r_a_key;
    logic                  r_a_sel;
    logic                  r_o_valid;
    msort_pkg::t_out_item  r_o_data;
    logic [KEY_W:0]        r_mem [MAX_ENTRIES];

    logic                  in_acc;
    logic                  room;
    logic                  out_acc;
    logic                  out_last;
    logic                  move_o;
    logic                  fetch;
    logic                  a_last;
    msort_pkg::t_chain_ctl chain_ctl;
    msort_pkg::t_entry     chain_new;
    msort_pkg::t_entry     chain_head;

    assign in_acc   = i_in_valid && o_in_ready;
    assign room     = r_count < CW'(MAX_ENTRIES);
    assign out_acc  = r_o_valid && i_out_ready;
    assign out_last = out_acc && r_o_data.last_result;
    assign move_o   = r_a_valid && (!r_o_valid || i_out_ready);
    assign fetch    = (r_state == msort_pkg::ST_DRAIN) && (r_fetch_pos < r_count)
                      && (!r_a_valid || move_o);
    assign a_last   = (CW'(r_a_pos) + CW'(1)) == r_count;

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msort_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            msort_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                if (in_acc && i_in_data.last_entry) begin
                    n_state = msort_pkg::ST_DRAIN;
                end
            end
            msort_pkg::ST_DRAIN: begin
                if (out_last) begin
                    n_state = msort_pkg::ST_LOAD;
                end
            end
            default: n_state = msort_pkg::ST_LOAD;
        endcase
    end

    // counters and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fetch_pos <= '0;
            r_a_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (in_acc && room) begin
                r_count <= r_count + CW'(1);
            end else if (out_last) begin
                r_count <= '0;
            end

            if (fetch) begin
                r_fetch_pos <= r_fetch_pos + CW'(1);
            end else if (out_last) begin
                r_fetch_pos <= '0;
            end

            if (fetch) begin
                r_a_valid <= 1'b1;
            end else if (move_o) begin
                r_a_valid <= 1'b0;
            end

            if (move_o) begin
                r_o_valid <= 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // position memory: key and selected flag per list position
    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            r_mem[r_count[AW-1:0]] <= {i_in_data.key, i_in_data.selected};
        end
        if (fetch) begin
            {r_a_key, r_a_sel} <= r_mem[r_fetch_pos[AW-1:0]];
            r_a_pos            <= r_fetch_pos[AW-1:0];
        end
    end

    // selected positions take the chain head in order; others keep their own entry
    always_ff @(posedge i_clk) begin
        if (move_o) begin
            r_o_data.position    <= IDX_W'(r_a_pos);
            r_o_data.last_result <= a_last;
            if (r_a_sel) begin
                r_o_data.source_index <= chain_head.idx;
                r_o_data.sorted_key   <= chain_head.key;
            end else begin
                r_o_data.source_index <= IDX_W'(r_a_pos);
                r_o_data.sorted_key   <= r_a_key;
            end
        end
    end

    assign chain_ctl.insert = in_acc && room && i_in_data.selected;
    assign chain_ctl.pop    = move_o && r_a_sel;
    assign chain_new.valid  = 1'b1;
    assign chain_new.key    = i_in_data.key;
    assign chain_new.idx    = IDX_W'(r_count[AW-1:0]);

    msort_chain #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (chain_ctl),
        .i_new   (chain_new),
        .o_head  (chain_head)
    );

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input open while results pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count past capacity");

    a_head_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move_o && r_a_sel) |-> chain_head.valid)
        else $error("selected position with empty chain");

    a_chain_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_last |-> !chain_head.valid)
        else $error("chain not empty at end of list");

    a_fetch_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fetch |-> !chain_ctl.insert)
        else $error("insert during drain");
`endif

endmodule

`default_nettype wire
